// ===== hw/rtl/tvn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_pkg: shared types and constants for the tileable value-noise generator
// Hash multipliers, fixed-point constants and the item passed along the row
// of octave cells.
// ----------------------------------------------------------------------------
package tvn_pkg;

    localparam int PIX_W    = 8;
    localparam int BW_W     = 5;
    localparam int SEED_W   = 32;
    localparam int VAL_W    = 8;
    // Binary point of the per-octave value (corner * Q23 * Q23)
    localparam int N_FRAC   = 46;

    localparam logic [31:0] HASH_CX = 32'd374761393;
    localparam logic [31:0] HASH_CY = 32'd668265263;
    localparam logic [31:0] HASH_CK = 32'd1013904223;
    localparam logic [31:0] HASH_CM = 32'd1274126177;

    // 1.0 in the Q23 smoothstep format
    localparam logic [23:0] ONE_Q23 = 24'd8388608;

    // Register indexes of the configuration port
    localparam logic REG_SEED      = 1'b0;
    localparam logic REG_BASE_WRAP = 1'b1;

    // Texel coordinate travelling from cell to cell
    typedef struct packed {
        logic             vld;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } t_item;

endpackage
`default_nettype wire

// ===== hw/rtl/tvn_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_cell: one octave of the noise sum
// Ten-stage pipeline: lattice position, corner hashes, smoothstep, bilinear
// blend, then adds its weighted value to the running sum of the cell before.
// ----------------------------------------------------------------------------
module tvn_cell #(
    parameter int OCT     = 0,
    parameter int OCTAVES = 4,
    parameter int TEX_LOG = 8,
    parameter int AW      = 66
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  tvn_pkg::t_item             i_item,
    input  wire [tvn_pkg::SEED_W-1:0]  i_seed,
    input  wire [tvn_pkg::BW_W-1:0]    i_bw,
    input  wire [AW-1:0]               i_acc,
    output tvn_pkg::t_item             o_item,
    output logic [AW-1:0]              o_acc,
    output logic                       o_acc_vld
);
    import tvn_pkg::*;

    localparam int CW   = BW_W + OCT;
    localparam int MW   = PIX_W + BW_W + OCT;
    localparam int SH_R = (TEX_LOG >= 8) ? TEX_LOG - 8 : 0;
    localparam int SH_L = (TEX_LOG < 8) ? 8 - TEX_LOG : 0;
    localparam logic [PIX_W-1:0] PIX_MASK =
        (TEX_LOG >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << TEX_LOG) - 1);
    localparam logic [31:0] FRAC_MASK = 32'((1 << TEX_LOG) - 1);
    localparam int NSTG = 10;

    t_item            r_item;
    logic [NSTG-1:0]  r_v;

    // stage 1: lattice
    logic [PIX_W-1:0] n_pxm, n_pym;
    logic [MW-1:0]    n_mx, n_my;
    logic [31:0]      n_frx, n_fry;
    logic [CW-1:0]    n_wrap, n_ix0, n_iy0, n_ix0p, n_iy0p;
    logic [CW-1:0]    r_ix0, r_ix1, r_iy0, r_iy1;
    logic [7:0]       r_fx1, r_fy1;
    // stage 2
    logic [31:0]      r_hx0, r_hx1, r_hy0, r_hy1, r_kp;
    logic [15:0]      r_ffx, r_ffy;
    logic [7:0]       r_fx2, r_fy2;
    // stage 3
    logic [31:0]      r_ha, r_hb, r_hc, r_hd;
    logic [23:0]      r_sx3, r_sy3;
    // stage 4
    logic [31:0]      n_ga, n_gb, n_gc, n_gd;
    logic [31:0]      r_pa, r_pb, r_pc, r_pd;
    logic [23:0]      r_sx4, r_sy4;
    // stage 5
    logic [15:0]      r_ca, r_cb, r_cc, r_cd;
    logic [23:0]      r_wx0, r_wx1, r_wy0_5, r_wy1_5;
    // stage 6
    logic [39:0]      r_ma, r_mb, r_mc, r_md;
    logic [23:0]      r_wy0_6, r_wy1_6;
    // stage 7
    logic [39:0]      r_top, r_bot;
    logic [23:0]      r_wy0_7, r_wy1_7;
    // stage 8
    logic [43:0]      r_pth, r_ptl, r_pbh, r_pbl;
    // stage 9, 10
    logic [63:0]      r_n;
    logic [AW-1:0]    r_acc;

    // Hand the coordinate on and track valid through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
            r_v        <= '0;
        end else begin
            r_item.vld <= i_item.vld;
            r_v        <= {r_v[NSTG-2:0], i_item.vld};
        end
        r_item.px <= i_item.px;
        r_item.py <= i_item.py;
    end

    // Lattice cell and fraction; pixel beyond the tile folds back first
    always_comb begin
        n_pxm  = i_item.px & PIX_MASK;
        n_pym  = i_item.py & PIX_MASK;
        n_mx   = (MW'(n_pxm) * MW'(i_bw)) << OCT;
        n_my   = (MW'(n_pym) * MW'(i_bw)) << OCT;
        n_frx  = 32'(n_mx) & FRAC_MASK;
        n_fry  = 32'(n_my) & FRAC_MASK;
        n_wrap = CW'(i_bw) << OCT;
        n_ix0  = CW'(n_mx >> TEX_LOG);
        n_iy0  = CW'(n_my >> TEX_LOG);
        n_ix0p = n_ix0 + CW'(1);
        n_iy0p = n_iy0 + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        r_ix0 <= n_ix0;
        r_iy0 <= n_iy0;
        r_ix1 <= (n_ix0p == n_wrap) ? '0 : n_ix0p;
        r_iy1 <= (n_iy0p == n_wrap) ? '0 : n_iy0p;
        r_fx1 <= 8'((n_frx << SH_L) >> SH_R);
        r_fy1 <= 8'((n_fry << SH_L) >> SH_R);
        // stage 2: coordinate products and square of the fraction
        r_hx0 <= 32'(32'(r_ix0) * HASH_CX);
        r_hx1 <= 32'(32'(r_ix1) * HASH_CX);
        r_hy0 <= 32'(32'(r_iy0) * HASH_CY);
        r_hy1 <= 32'(32'(r_iy1) * HASH_CY);
        r_kp  <= 32'((i_seed + 32'(OCT)) * HASH_CK);
        r_ffx <= 16'(16'(r_fx1) * 16'(r_fx1));
        r_ffy <= 16'(16'(r_fy1) * 16'(r_fy1));
        r_fx2 <= r_fx1;
        r_fy2 <= r_fy1;
        // stage 3: hash sums and smoothstep
        r_ha  <= r_hx0 + r_hy0 + r_kp;
        r_hb  <= r_hx1 + r_hy0 + r_kp;
        r_hc  <= r_hx0 + r_hy1 + r_kp;
        r_hd  <= r_hx1 + r_hy1 + r_kp;
        r_sx3 <= 24'(25'(r_ffx) * 25'(9'd384 - {1'b0, r_fx2}));
        r_sy3 <= 24'(25'(r_ffy) * 25'(9'd384 - {1'b0, r_fy2}));
    end

    always_comb begin
        n_ga = r_ha ^ (r_ha >> 13);
        n_gb = r_hb ^ (r_hb >> 13);
        n_gc = r_hc ^ (r_hc >> 13);
        n_gd = r_hd ^ (r_hd >> 13);
    end

    always_ff @(posedge i_clk) begin
        // stage 4: hash mix multiply
        r_pa  <= 32'(n_ga * HASH_CM);
        r_pb  <= 32'(n_gb * HASH_CM);
        r_pc  <= 32'(n_gc * HASH_CM);
        r_pd  <= 32'(n_gd * HASH_CM);
        r_sx4 <= r_sx3;
        r_sy4 <= r_sy3;
        // stage 5: corner values and blend weights
        r_ca    <= r_pa[15:0] ^ r_pa[31:16];
        r_cb    <= r_pb[15:0] ^ r_pb[31:16];
        r_cc    <= r_pc[15:0] ^ r_pc[31:16];
        r_cd    <= r_pd[15:0] ^ r_pd[31:16];
        r_wx0   <= ONE_Q23 - r_sx4;
        r_wx1   <= r_sx4;
        r_wy0_5 <= ONE_Q23 - r_sy4;
        r_wy1_5 <= r_sy4;
        // stage 6: row products
        r_ma    <= 40'(40'(r_ca) * 40'(r_wx0));
        r_mb    <= 40'(40'(r_cb) * 40'(r_wx1));
        r_mc    <= 40'(40'(r_cc) * 40'(r_wx0));
        r_md    <= 40'(40'(r_cd) * 40'(r_wx1));
        r_wy0_6 <= r_wy0_5;
        r_wy1_6 <= r_wy1_5;
        // stage 7: row sums
        r_top   <= r_ma + r_mb;
        r_bot   <= r_mc + r_md;
        r_wy0_7 <= r_wy0_6;
        r_wy1_7 <= r_wy1_6;
        // stage 8: column products, rows split in halves of 20 bits
        r_pth <= 44'(44'(r_top[39:20]) * 44'(r_wy0_7));
        r_ptl <= 44'(44'(r_top[19:0])  * 44'(r_wy0_7));
        r_pbh <= 44'(44'(r_bot[39:20]) * 44'(r_wy1_7));
        r_pbl <= 44'(44'(r_bot[19:0])  * 44'(r_wy1_7));
        // stage 9: recombine octave value
        r_n   <= ((64'(r_pth) + 64'(r_pbh)) << 20) + 64'(r_ptl) + 64'(r_pbl);
        // stage 10: weight and add to the sum from the cell before
        r_acc <= i_acc + (AW'(r_n) << (OCTAVES - 1 - OCT));
    end

    assign o_item    = r_item;
    assign o_acc     = r_acc;
    assign o_acc_vld = r_v[NSTG-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tvn_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_div: final scale to 0..255
// Divides the integer part of the weighted sum by 257 times the weight sum
// through a reciprocal multiply with one correction step, then clamps.
// ----------------------------------------------------------------------------
module tvn_div #(
    parameter int OCTAVES = 4,
    parameter int AW      = 66
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_vld,
    input  wire [AW-1:0]               i_acc,
    output logic                       o_vld,
    output logic [tvn_pkg::VAL_W-1:0]  o_value
);
    import tvn_pkg::*;

    localparam int TW = AW - N_FRAC;
    localparam logic [31:0] DIVISOR = 32'(257 * ((1 << OCTAVES) - 1));
    localparam logic [63:0] RECIP   = (64'd1 << 32) / DIVISOR;

    logic          r_vld1;
    logic [TW-1:0] r_tot, r_qe;
    logic [63:0]   n_rem;
    logic [TW-1:0] n_q;

    // Estimate the quotient, at most one short
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
        r_tot <= i_acc[AW-1:N_FRAC];
        r_qe  <= TW'((64'(i_acc[AW-1:N_FRAC]) * RECIP) >> 32);
    end

    // Correct the estimate and clamp
    always_comb begin
        n_rem = 64'(r_tot) - 64'(r_qe) * 64'(DIVISOR);
        n_q   = (n_rem >= 64'(DIVISOR)) ? r_qe + TW'(1) : r_qe;
    end

    always_ff @(posedge i_clk) begin
        o_value <= (n_q > TW'(255)) ? 8'd255 : n_q[VAL_W-1:0];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tileable_value_noise_fbm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tileable_value_noise_fbm: tileable fBM value-noise texel generator
// Row of octave cells summing weighted value noise, then scale and clamp.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   start, i_pixel_x, i_pixel_y             taken when start & !busy
//  result    o_valid, o_noise_value                  one-cycle strobe
//  config    i_cfg_we, i_cfg_idx, i_cfg_data         write when i_cfg_we
//
//  One item accepted every cycle; busy is never raised.
//  The accepting edge loads the input register; the item then passes
//  ten stages in the first cell, one more per further cell and two in
//  the final divide before the result strobe rises.
//  Reset clears the pipeline valid bits and loads seed 1337, base_wrap 4.
//  The result strobe cannot be held off, so nothing in the pipe stalls.
// ----------------------------------------------------------------------------
module tileable_value_noise_fbm #(
    parameter int TEX_SIZE = 256,
    parameter int OCTAVES  = 4
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [tvn_pkg::PIX_W-1:0]    i_pixel_x,
    input  wire [tvn_pkg::PIX_W-1:0]    i_pixel_y,
    output logic                        o_valid,
    output logic [tvn_pkg::VAL_W-1:0]   o_noise_value,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_idx,
    input  wire [tvn_pkg::SEED_W-1:0]   i_cfg_data
);
    import tvn_pkg::*;

    localparam int TEX_LOG = $clog2(TEX_SIZE);
    localparam int AW      = 62 + OCTAVES;
    localparam int LAT     = OCTAVES + 11;

    logic [SEED_W-1:0] r_seed;
    logic [BW_W-1:0]   r_base_wrap;
    logic [BW_W-1:0]   n_bw;
    t_item             r_in;
    t_item             items [OCTAVES+1];
    logic [AW-1:0]     accs  [OCTAVES+1];
    logic              vlds  [OCTAVES];

    assign busy = 1'b0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= 32'd1337;
            r_base_wrap <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEED:      r_seed      <= i_cfg_data;
                REG_BASE_WRAP: r_base_wrap <= i_cfg_data[BW_W-1:0];
                default:       r_seed      <= r_seed;
            endcase
        end
    end

    // Zero wrap count means one cell
    assign n_bw = (r_base_wrap == '0) ? BW_W'(1) : r_base_wrap;

    // Register the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= start && !busy;
        end
        r_in.px <= i_pixel_x;
        r_in.py <= i_pixel_y;
    end

    assign items[0] = r_in;
    assign accs[0]  = '0;

    // Row of octave cells
    for (genvar g = 0; g < OCTAVES; g++) begin : g_cell
        tvn_cell #(
            .OCT     (g),
            .OCTAVES (OCTAVES),
            .TEX_LOG (TEX_LOG),
            .AW      (AW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_item    (items[g]),
            .i_seed    (r_seed),
            .i_bw      (n_bw),
            .i_acc     (accs[g]),
            .o_item    (items[g+1]),
            .o_acc     (accs[g+1]),
            .o_acc_vld (vlds[g])
        );
    end

    tvn_div #(
        .OCTAVES (OCTAVES),
        .AW      (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vlds[OCTAVES-1]),
        .i_acc   (accs[OCTAVES]),
        .o_vld   (o_valid),
        .o_value (o_noise_value)
    );

    // A result only follows an accepted item; the strobe is seen at the edge after it rises
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT + 1))
        else $error("result without accepted item");

    // Last cell sum reaches the output after the divide
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vlds[OCTAVES-1] |-> ##2 o_valid)
        else $error("divide stage lost an item");

    // First cell valid tracks the input register
    a_cell_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in.vld |-> ##10 vlds[0])
        else $error("first cell dropped an item");

endmodule
`default_nettype wire
